### rtl/sab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// Shared sizes, codes and address helper for the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int MAX_TEXT   = 4096;
	localparam int ALPHABET   = 26;
	localparam int MAX_STATES = 2 * MAX_TEXT;
	localparam int ROW_DEPTH  = MAX_STATES + 1;
	localparam int TAB_DEPTH  = ROW_DEPTH * ALPHABET;
	localparam int ST_W       = 14;
	localparam int LEN_W      = 13;
	localparam int SYM_W      = 5;
	localparam int TA_W       = $clog2(TAB_DEPTH);
	localparam int RA_W       = $clog2(ROW_DEPTH);
	localparam int CNT_W      = $clog2(ALPHABET + 1);

	localparam logic [ST_W-1:0] ROOT = ST_W'(1);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		FN_APPEND = 1'b0,
		FN_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DEC, S_CLR, S_WRD, S_WCHK, S_QCHK,
		S_COPY, S_RRD, S_RCHK, S_FIX, S_FIX2, S_LKT, S_LKW, S_OUT
	} seq_t;

	// Table address of one transition: row times the alphabet size plus the letter.
	function automatic logic [TA_W-1:0] taddr(input logic [ST_W-1:0] row,
	                                          input logic [SYM_W-1:0] c);
		logic [TA_W+ST_W-1:0] prod;
		begin
			prod = (TA_W+ST_W)'(row) * (TA_W+ST_W)'(ALPHABET) + (TA_W+ST_W)'(c);
			return prod[TA_W-1:0];
		end
	endfunction

endpackage

### rtl/sab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/suffix_automaton_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder_unit
// Online suffix automaton construction with transition lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready is high only while the block is
// idle. A lookup reads the transition and then the target's length and link
// before it answers; it skips the second read when the state has no transition
// on the letter, and an out-of-range request answers straight from decode, as
// does a rejected append. An append decodes, clears the new state's transition
// row, then reads and checks each state visited on the suffix-link walk, and
// checks the target's length when an existing transition ends the walk. A clone
// copies the row, redirects transitions while walking the suffix links, and
// fixes the links of the old target and the new state. The row clear and copy
// move one transition entry per cycle. After reset the block clears the root
// row before it takes its first request.
// Rows of states that were never created are never read.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_unit
	import sab_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             func,
	input  logic [SYM_W-1:0] symbol,
	input  logic [ST_W-1:0]  node,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [1:0]       status,
	output logic [ST_W-1:0]  next_state,
	output logic [LEN_W-1:0] state_len,
	output logic [ST_W-1:0]  state_link,
	output logic [ST_W-1:0]  state_count,
	output logic             cloned
);

	seq_t state_q, state_d;

	// Memory ports.
	logic             t_we;
	logic [TA_W-1:0]  t_wa, t_ra;
	logic [ST_W-1:0]  t_wd, t_rd;
	logic             l_we;
	logic [RA_W-1:0]  l_wa, l_ra;
	logic [LEN_W-1:0] l_wd, l_rd;
	logic             k_we;
	logic [RA_W-1:0]  k_wa, k_ra;
	logic [ST_W-1:0]  k_wd, k_rd;

	// Working registers.
	logic             func_q;
	logic [SYM_W-1:0] sym_q;
	logic [ST_W-1:0]  node_q;
	logic [ST_W-1:0]  su_q, last_q, cur_q, cl_q, p_q, q_q;
	logic [LEN_W-1:0] tlen_q, lenp_q, lencur_q;
	logic [CNT_W-1:0] cnt_q;
	logic             clflag_q;

	// Response registers.
	logic [1:0]       status_q;
	logic [ST_W-1:0]  next_q, link_q;
	logic [LEN_W-1:0] len_q;
	logic             cloned_q;

	logic             finish_ok;
	logic [ST_W-1:0]  fin_link;
	logic [CNT_W-1:0] cnt_m1;

	assign cnt_m1 = cnt_q - CNT_W'(1);

	sab_ram #(.WIDTH(ST_W), .DEPTH(TAB_DEPTH)) u_trans (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
	);
	sab_ram #(.WIDTH(LEN_W), .DEPTH(ROW_DEPTH)) u_len (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	sab_ram #(.WIDTH(ST_W), .DEPTH(ROW_DEPTH)) u_link (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
	);

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d   = state_q;
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
		k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
		finish_ok = 1'b0;
		fin_link  = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			S_INIT: begin
				t_we = 1'b1;
				t_wa = taddr(ROOT, SYM_W'(cnt_q));
				if (cnt_q == '0) begin
					l_we = 1'b1; l_wa = RA_W'(ROOT);
					k_we = 1'b1; k_wa = RA_W'(ROOT);
				end
				if (cnt_q == CNT_W'(ALPHABET - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (func_q == FN_LOOKUP) begin
					if (sym_q >= SYM_W'(ALPHABET) || node_q == '0 || node_q > su_q) begin
						state_d = S_OUT;
					end else begin
						t_ra    = taddr(node_q, sym_q);
						state_d = S_LKT;
					end
				end else if (tlen_q >= LEN_W'(MAX_TEXT) || sym_q >= SYM_W'(ALPHABET)) begin
					state_d = S_OUT;
				end else begin
					l_ra    = RA_W'(last_q);
					state_d = S_CLR;
				end
			end
			S_CLR: begin
				t_we = 1'b1;
				t_wa = taddr(cur_q, SYM_W'(cnt_q));
				if (cnt_q == '0) begin
					l_we = 1'b1; l_wa = RA_W'(cur_q); l_wd = l_rd + LEN_W'(1);
				end
				if (cnt_q == CNT_W'(ALPHABET - 1)) state_d = S_WRD;
			end
			S_WRD: begin
				t_ra = taddr(p_q, sym_q);
				l_ra = RA_W'(p_q);
				k_ra = RA_W'(p_q);
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (t_rd == '0) begin
					t_we = 1'b1; t_wa = taddr(p_q, sym_q); t_wd = cur_q;
					if (k_rd == '0) begin
						k_we = 1'b1; k_wa = RA_W'(cur_q); k_wd = ROOT;
						finish_ok = 1'b1; fin_link = ROOT;
					end else begin
						state_d = S_WRD;
					end
				end else begin
					l_ra = RA_W'(t_rd);
					k_ra = RA_W'(t_rd);
					state_d = S_QCHK;
				end
			end
			S_QCHK: begin
				if (lenp_q + LEN_W'(1) == l_rd) begin
					k_we = 1'b1; k_wa = RA_W'(cur_q); k_wd = q_q;
					finish_ok = 1'b1; fin_link = q_q;
				end else begin
					l_we = 1'b1; l_wa = RA_W'(su_q + ST_W'(1)); l_wd = lenp_q + LEN_W'(1);
					k_we = 1'b1; k_wa = RA_W'(su_q + ST_W'(1)); k_wd = k_rd;
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				if (cnt_q < CNT_W'(ALPHABET)) t_ra = taddr(q_q, SYM_W'(cnt_q));
				if (cnt_q != '0) begin
					t_we = 1'b1; t_wa = taddr(cl_q, SYM_W'(cnt_m1)); t_wd = t_rd;
				end
				if (cnt_q == CNT_W'(ALPHABET)) state_d = S_RRD;
			end
			S_RRD: begin
				t_ra = taddr(p_q, sym_q);
				k_ra = RA_W'(p_q);
				state_d = S_RCHK;
			end
			S_RCHK: begin
				if (t_rd == q_q) begin
					t_we = 1'b1; t_wa = taddr(p_q, sym_q); t_wd = cl_q;
					state_d = (k_rd == '0) ? S_FIX : S_RRD;
				end else begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				k_we = 1'b1; k_wa = RA_W'(q_q); k_wd = cl_q;
				state_d = S_FIX2;
			end
			S_FIX2: begin
				k_we = 1'b1; k_wa = RA_W'(cur_q); k_wd = cl_q;
				finish_ok = 1'b1; fin_link = cl_q;
			end
			S_LKT: begin
				if (t_rd == '0) begin
					state_d = S_OUT;
				end else begin
					l_ra = RA_W'(t_rd);
					k_ra = RA_W'(t_rd);
					state_d = S_LKW;
				end
			end
			S_LKW: state_d = S_OUT;
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (finish_ok) state_d = S_OUT;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers of the automaton.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q     <= ROOT;
			last_q   <= ROOT;
			tlen_q   <= '0;
			cnt_q    <= '0;
			clflag_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT, S_CLR, S_COPY: begin
					cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
				end
				S_DEC: begin
					cnt_q    <= '0;
					clflag_q <= 1'b0;
					if (state_d == S_CLR) su_q <= su_q + ST_W'(1);
				end
				S_QCHK: begin
					if (state_d == S_COPY) begin
						su_q     <= su_q + ST_W'(1);
						clflag_q <= 1'b1;
						cnt_q    <= '0;
					end
				end
				default: ;
			endcase
			if (finish_ok) begin
				last_q <= cur_q;
				tlen_q <= tlen_q + LEN_W'(1);
			end
		end
	end

	// Payload registers of the current request.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			func_q <= func;
			sym_q  <= symbol;
			node_q <= node;
		end
		case (state_q)
			S_DEC: begin
				cur_q <= su_q + ST_W'(1);
				p_q   <= last_q;
			end
			S_CLR: begin
				if (cnt_q == '0) lencur_q <= l_rd + LEN_W'(1);
			end
			S_WCHK: begin
				if (t_rd == '0) begin
					p_q <= k_rd;
				end else begin
					q_q    <= t_rd;
					lenp_q <= l_rd;
				end
			end
			S_QCHK: cl_q <= su_q + ST_W'(1);
			S_RCHK: if (t_rd == q_q) p_q <= k_rd;
			default: ;
		endcase
	end

	// Response registers.
	always_ff @(posedge clk) begin
		if (finish_ok) begin
			status_q <= ST_OK;
			next_q   <= cur_q;
			len_q    <= lencur_q;
			link_q   <= fin_link;
			cloned_q <= clflag_q;
		end else begin
			case (state_q)
				S_DEC: begin
					status_q <= (func_q == FN_APPEND && tlen_q >= LEN_W'(MAX_TEXT))
					            ? ST_FULL : ST_RANGE;
					next_q   <= '0;
					len_q    <= '0;
					link_q   <= '0;
					cloned_q <= 1'b0;
				end
				S_LKT: begin
					status_q <= ST_OK;
					next_q   <= t_rd;
				end
				S_LKW: begin
					len_q  <= l_rd;
					link_q <= k_rd;
				end
				default: ;
			endcase
		end
	end

	assign status      = status_q;
	assign next_state  = next_q;
	assign state_len   = len_q;
	assign state_link  = link_q;
	assign state_count = su_q;
	assign cloned      = cloned_q;

	// Checks.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a response is pending");

	a_clone_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cloned |-> status == ST_OK)
		else $error("clone reported on a failed request");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		su_q >= $past(su_q))
		else $error("state count went down");

	a_text_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tlen_q <= LEN_W'(MAX_TEXT))
		else $error("text length beyond capacity");

endmodule
